// File: rtl/sfd_pkg.sv
// ----------------------------------------------------------------------------
// sfd_pkg
// Shared types, protocol constants and the CRC-16 byte update for the
// sensor frame decoder.
// ----------------------------------------------------------------------------
package sfd_pkg;

  localparam int          MAX_PAYLOAD_DEF = 256;
  localparam int          REPLY_LEN       = 8;

  localparam logic [7:0]  SYNC_BYTE  = 8'h5A;
  localparam logic [7:0]  TYPE_DATA  = 8'hA5;
  localparam logic [7:0]  TYPE_PING  = 8'hA6;
  localparam logic [7:0]  TYPE_REPLY = 8'hA7;
  localparam logic [15:0] CRC_POLY   = 16'h1021;

  typedef enum logic [2:0] {
    PH_IDLE = 3'd0,
    PH_TYPE = 3'd1,
    PH_LENL = 3'd2,
    PH_LENH = 3'd3,
    PH_CRCL = 3'd4,
    PH_CRCH = 3'd5,
    PH_DATA = 3'd6
  } phase_e;

  typedef enum logic [1:0] {
    KIND_DATA  = 2'd0,
    KIND_PING  = 2'd1,
    KIND_REPLY = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_CRC_ERR  = 2'd1,
    ST_OVERFLOW = 2'd2
  } status_e;

  // CRC-16, MSB first, one byte: eight shift/xor steps.
  function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

  // CRC after the fixed header bytes of a data frame.
  localparam logic [15:0] CRC_HDR = crc16_byte(crc16_byte(16'h0000, SYNC_BYTE), TYPE_DATA);

endpackage

// File: rtl/sensor_frame_decoder_crc16.sv
// ----------------------------------------------------------------------------
// sensor_frame_decoder_crc16
// Byte-stream parser for sync-framed serial data, ping and ping reply frames
// with a running CRC-16 check on data frames.
// ----------------------------------------------------------------------------
// One received byte enters per transfer on the slave side, and the block takes
// a new byte in every cycle while the master side keeps up. A result that
// waits on the master side holds the decode stage; the input register then
// takes at most one more byte before tready drops. An input register feeds a
// single decode stage (state transition plus a byte-wide unrolled CRC-16
// update), whose result is held in an output register. Header bytes (sync,
// type, length, CRC) give no transfer; each payload byte gives one, and a ping
// or an empty data frame gives one transfer without a byte. tlast marks the
// final transfer of a frame, whose status says ok, CRC mismatch or overflow
// (MAX_PAYLOAD payload bytes reached, which ends the frame at once). The CRC
// (poly 0x1021, init 0, no final xor) covers 5A A5 lenL lenH and the payload.
module sensor_frame_decoder_crc16 #(
  parameter int MAX_PAYLOAD = sfd_pkg::MAX_PAYLOAD_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] rx_byte
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [23:0] m_axis_tdata_o,   // [7:0] data_byte, [15:8] byte_index, [17:16] status
  output logic [2:0]  m_axis_tuser_o,   // [1:0] frame_kind, [2] has_byte
  output logic        m_axis_tlast_o
);
  import sfd_pkg::*;

  localparam int            CW      = $clog2(MAX_PAYLOAD + 1);
  localparam logic [CW-1:0] MAX_CNT = CW'(MAX_PAYLOAD);
  localparam logic [CW-1:0] RPL_CNT = CW'(REPLY_LEN);

  // Input register
  logic       in_valid_q;
  logic [7:0] in_byte_q;

  // Parser state
  phase_e        phase_q, phase_d;
  kind_e         type_q, type_d;
  logic [15:0]   len_q, len_d;
  logic [15:0]   crc_rx_q, crc_rx_d;
  logic [15:0]   crc_q, crc_d;
  logic [CW-1:0] cnt_q, cnt_d;

  // Output register
  logic       out_valid_q;
  logic [7:0] out_data_q, out_idx_q;
  kind_e      out_kind_q;
  logic       out_has_q, out_last_q;
  status_e    out_status_q;

  // Decode-stage result
  logic          emit;
  logic [7:0]    e_data, e_idx;
  kind_e         e_kind;
  logic          e_has, e_last;
  status_e       e_status;
  logic [15:0]   crc_in;
  logic [CW-1:0] cnt_inc;

  logic out_free, fire;

  // Advance the decode stage when the output register is empty or drains now.
  assign out_free        = !out_valid_q || m_axis_tready_i;
  assign fire            = in_valid_q && out_free;
  assign s_axis_tready_o = !in_valid_q || fire;

  assign crc_in  = crc16_byte(crc_q, in_byte_q);
  assign cnt_inc = cnt_q + 1'b1;

  always_comb begin
    phase_d  = phase_q;
    type_d   = type_q;
    len_d    = len_q;
    crc_rx_d = crc_rx_q;
    crc_d    = crc_q;
    cnt_d    = cnt_q;
    emit     = 1'b0;
    e_data   = 8'h00;
    e_idx    = 8'h00;
    e_kind   = KIND_DATA;
    e_has    = 1'b0;
    e_last   = 1'b0;
    e_status = ST_OK;
    case (phase_q)
      PH_TYPE: begin
        if (in_byte_q == TYPE_DATA) begin
          type_d  = KIND_DATA;
          crc_d   = CRC_HDR;
          phase_d = PH_LENL;
        end else if (in_byte_q == TYPE_PING) begin
          type_d  = KIND_PING;
          phase_d = PH_IDLE;
          emit    = 1'b1;
          e_kind  = KIND_PING;
          e_last  = 1'b1;
        end else if (in_byte_q == TYPE_REPLY) begin
          type_d  = KIND_REPLY;
          cnt_d   = '0;
          phase_d = PH_DATA;
        end
        // any other type byte: drop it, keep waiting for a type byte
      end
      PH_LENL: begin
        len_d   = {8'h00, in_byte_q};
        crc_d   = crc_in;
        phase_d = PH_LENH;
      end
      PH_LENH: begin
        len_d   = {in_byte_q, len_q[7:0]};
        crc_d   = crc_in;
        phase_d = PH_CRCL;
      end
      PH_CRCL: begin
        crc_rx_d = {8'h00, in_byte_q};
        phase_d  = PH_CRCH;
      end
      PH_CRCH: begin
        crc_rx_d = {in_byte_q, crc_rx_q[7:0]};
        cnt_d    = '0;
        if (len_q == 16'h0000) begin
          // empty frame: status from the header CRC alone
          phase_d  = PH_IDLE;
          emit     = 1'b1;
          e_last   = 1'b1;
          e_status = (crc_q == {in_byte_q, crc_rx_q[7:0]}) ? ST_OK : ST_CRC_ERR;
        end else begin
          phase_d = PH_DATA;
        end
      end
      PH_DATA: begin
        cnt_d  = cnt_inc;
        emit   = 1'b1;
        e_data = in_byte_q;
        e_idx  = 8'(cnt_q);
        e_has  = 1'b1;
        if (type_q == KIND_REPLY) begin
          e_kind = KIND_REPLY;
          if (cnt_inc >= RPL_CNT) begin
            phase_d = PH_IDLE;
            e_last  = 1'b1;
          end
        end else begin
          crc_d = crc_in;
          if (cnt_inc >= MAX_CNT) begin
            phase_d  = PH_IDLE;
            e_last   = 1'b1;
            e_status = ST_OVERFLOW;
          end else if (16'(cnt_inc) >= len_q) begin
            phase_d  = PH_IDLE;
            e_last   = 1'b1;
            e_status = (crc_in == crc_rx_q) ? ST_OK : ST_CRC_ERR;
          end
        end
      end
      default: begin
        // idle and unused codes: hunt for sync
        phase_d = (in_byte_q == SYNC_BYTE) ? PH_TYPE : PH_IDLE;
      end
    endcase
  end

  // Control and parser state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      phase_q     <= PH_IDLE;
      type_q      <= KIND_DATA;
      len_q       <= '0;
      crc_rx_q    <= '0;
      crc_q       <= '0;
      cnt_q       <= '0;
    end else begin
      if (s_axis_tready_o) begin
        in_valid_q <= s_axis_tvalid_i;
      end
      if (fire) begin
        out_valid_q <= emit;
        phase_q     <= phase_d;
        type_q      <= type_d;
        len_q       <= len_d;
        crc_rx_q    <= crc_rx_d;
        crc_q       <= crc_d;
        cnt_q       <= cnt_d;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers: load on transfer or on decode advance
  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid_i && s_axis_tready_o) begin
      in_byte_q <= s_axis_tdata_i;
    end
    if (fire && emit) begin
      out_data_q   <= e_data;
      out_idx_q    <= e_idx;
      out_kind_q   <= e_kind;
      out_has_q    <= e_has;
      out_last_q   <= e_last;
      out_status_q <= e_status;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {6'b000000, out_status_q, out_idx_q, out_data_q};
  assign m_axis_tuser_o  = {out_has_q, out_kind_q};
  assign m_axis_tlast_o  = out_last_q;

`ifndef ASSERT_OFF
  // A transfer without a payload byte is always the end of a frame.
  a_nobyte_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tuser_o[2]) |-> m_axis_tlast_o)
    else $error("transfer without byte not marked last");

  // A non-ok status appears only on the last transfer.
  a_status_on_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && (out_status_q != ST_OK)) |-> m_axis_tlast_o)
    else $error("error status before end of frame");

  // Ping replies never carry an error status.
  a_reply_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && (out_kind_q == KIND_REPLY)) |-> (out_status_q == ST_OK))
    else $error("ping reply with error status");

  // A byte held in the input register stays until the decode stage takes it.
  a_input_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && !out_free) |=> (in_valid_q && $stable(in_byte_q)))
    else $error("input register lost a byte while stalled");
`endif

endmodule

// File: tb/sv/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the sync-framed serial decoder with CRC-16. A
// driver feeds received bytes from a queue, a monitor predicts every decoded
// transfer from its own copy of the parser state and checks the master side
// field by field. Both sides idle at random, and the receiver holds off once
// for a long stretch so that the decoder backs up into its input.
// ----------------------------------------------------------------------------
module tb_top;
  import sfd_pkg::*;

  localparam int MAX_PAY     = MAX_PAYLOAD_DEF;
  localparam int RAND_BYTES  = 350;   // random part stops once at least this many bytes are queued
  localparam int IDLE_LIMIT  = 2000;  // cycles without any transfer
  localparam int HOLD_AT     = 40;    // results taken before the long hold-off
  localparam int HOLD_LEN    = 400;
  localparam int TAIL_CYCLES = 20;    // settling margin after the drain

  // One decoded transfer as seen on the master side.
  typedef struct {
    logic [7:0] data_byte;
    logic [7:0] byte_index;
    kind_e      kind;
    logic       has_byte;
    logic       last;
    status_e    status;
  } frame_beat_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = 8'h00;   // [7:0] rx_byte
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;           // [7:0] data_byte, [15:8] byte_index, [17:16] status
  logic [2:0]  m_axis_tuser;           // [1:0] frame_kind, [2] has_byte
  logic        m_axis_tlast;

  logic [7:0]  rx_stream_q[$];         // bytes still to be offered
  frame_beat_t decoded_q[$];           // predicted transfers, oldest first

  // Parser state of the predictor
  phase_e      dec_phase = PH_IDLE;
  kind_e       dec_kind  = KIND_DATA;
  logic [15:0] dec_len     = '0;
  logic [15:0] dec_crc_rx  = '0;
  logic [15:0] dec_crc_run = '0;
  logic [8:0]  dec_count   = '0;

  // Handshake flags, set at the rising edge and read at the falling edge
  bit src_took, sink_took;
  int quiet_cycles, errors;
  int bytes_sent, results_got;
  int src_gap, sink_wait, hold_left;
  bit src_burst, sink_burst, hold_done;
  int n_data_ok, n_data_crc, n_data_ovf, n_pings, n_replies;

  sensor_frame_decoder_crc16 #(
    .MAX_PAYLOAD(MAX_PAY)
  ) dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_o (s_axis_tready),
    .s_axis_tdata_i  (s_axis_tdata),
    .m_axis_tvalid_o (m_axis_tvalid),
    .m_axis_tready_i (m_axis_tready),
    .m_axis_tdata_o  (m_axis_tdata),
    .m_axis_tuser_o  (m_axis_tuser),
    .m_axis_tlast_o  (m_axis_tlast)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  // --------------------------------------------------------------------------
  // Prediction
  // --------------------------------------------------------------------------

  // CRC-16/XMODEM, one data bit at a time from the MSB.
  function automatic logic [15:0] crc16_step(input logic [15:0] crc, input logic [7:0] b);
    logic fb;
    for (int i = 7; i >= 0; i--) begin
      fb  = crc[15] ^ b[i];
      crc = {crc[14:0], 1'b0} ^ (fb ? CRC_POLY : 16'h0000);
    end
    return crc;
  endfunction

  function automatic void push_beat(input logic [7:0] d, input logic [7:0] idx, input kind_e k,
                                    input logic has, input logic lst, input status_e st);
    frame_beat_t beat;
    beat.data_byte  = d;
    beat.byte_index = idx;
    beat.kind       = k;
    beat.has_byte   = has;
    beat.last       = lst;
    beat.status     = st;
    decoded_q.push_back(beat);
  endfunction

  // Advance the parser by one received byte and queue what it should emit.
  task automatic frame_decode_step(input logic [7:0] b);
    logic [7:0] idx;
    idx = dec_count[7:0];
    case (dec_phase)
      PH_TYPE: begin
        // Any other type byte, a repeated sync included, leaves us waiting here
        if (b == TYPE_DATA) begin
          dec_kind    = KIND_DATA;
          dec_crc_run = crc16_step(crc16_step(16'h0000, SYNC_BYTE), TYPE_DATA);
          dec_phase   = PH_LENL;
        end else if (b == TYPE_PING) begin
          dec_kind  = KIND_PING;
          dec_phase = PH_IDLE;
          push_beat(8'h00, 8'h00, KIND_PING, 1'b0, 1'b1, ST_OK);
        end else if (b == TYPE_REPLY) begin
          dec_kind  = KIND_REPLY;
          dec_count = '0;
          dec_phase = PH_DATA;
        end
      end
      PH_LENL: begin
        dec_len     = {8'h00, b};
        dec_crc_run = crc16_step(dec_crc_run, b);
        dec_phase   = PH_LENH;
      end
      PH_LENH: begin
        dec_len[15:8] = b;
        dec_crc_run   = crc16_step(dec_crc_run, b);
        dec_phase     = PH_CRCL;
      end
      PH_CRCL: begin
        dec_crc_rx = {8'h00, b};
        dec_phase  = PH_CRCH;
      end
      PH_CRCH: begin
        dec_crc_rx[15:8] = b;
        dec_count        = '0;
        if (dec_len == 16'h0000) begin
          // Empty frame: one byteless transfer, CRC over the header alone
          dec_phase = PH_IDLE;
          push_beat(8'h00, 8'h00, KIND_DATA, 1'b0, 1'b1,
                    (dec_crc_run == dec_crc_rx) ? ST_OK : ST_CRC_ERR);
        end else begin
          dec_phase = PH_DATA;
        end
      end
      PH_DATA: begin
        dec_count = dec_count + 9'd1;
        if (dec_kind == KIND_REPLY) begin
          if (dec_count >= REPLY_LEN) begin
            dec_phase = PH_IDLE;
            push_beat(b, idx, KIND_REPLY, 1'b1, 1'b1, ST_OK);
          end else begin
            push_beat(b, idx, KIND_REPLY, 1'b1, 1'b0, ST_OK);
          end
        end else begin
          dec_crc_run = crc16_step(dec_crc_run, b);
          if (dec_count >= MAX_PAY) begin
            // Overflow wins even over a frame that would end on this byte
            dec_phase = PH_IDLE;
            push_beat(b, idx, KIND_DATA, 1'b1, 1'b1, ST_OVERFLOW);
          end else if (dec_count >= dec_len) begin
            dec_phase = PH_IDLE;
            push_beat(b, idx, KIND_DATA, 1'b1, 1'b1,
                      (dec_crc_run == dec_crc_rx) ? ST_OK : ST_CRC_ERR);
          end else begin
            push_beat(b, idx, KIND_DATA, 1'b1, 1'b0, ST_OK);
          end
        end
      end
      default: dec_phase = (b == SYNC_BYTE) ? PH_TYPE : PH_IDLE;
    endcase
  endtask

  // --------------------------------------------------------------------------
  // Checking
  // --------------------------------------------------------------------------

  function automatic void cmp_field(input string what, input logic [7:0] want,
                                    input logic [7:0] got);
    if (got !== want) begin
      $display("%0t ns: %s mismatch, expected %0h, got %0h", $time, what, want, got);
      errors++;
    end
  endfunction

  task automatic check_beat();
    frame_beat_t want;
    if (decoded_q.size() == 0) begin
      $display("%0t ns: unexpected transfer, expected none, got data %0h index %0h tuser %0h",
               $time, m_axis_tdata[7:0], m_axis_tdata[15:8], m_axis_tuser);
      errors++;
    end else begin
      want = decoded_q.pop_front();
      cmp_field("data_byte",  want.data_byte,  m_axis_tdata[7:0]);
      cmp_field("byte_index", want.byte_index, m_axis_tdata[15:8]);
      cmp_field("status",     8'(want.status),   8'(m_axis_tdata[17:16]));
      cmp_field("frame_kind", 8'(want.kind),     8'(m_axis_tuser[1:0]));
      cmp_field("has_byte",   8'(want.has_byte), 8'(m_axis_tuser[2]));
      cmp_field("tlast",      8'(want.last),     8'(m_axis_tlast));
      if (want.last) begin
        case (want.kind)
          KIND_PING:  n_pings++;
          KIND_REPLY: n_replies++;
          default: begin
            if (want.status == ST_OVERFLOW) n_data_ovf++;
            else if (want.status == ST_CRC_ERR) n_data_crc++;
            else n_data_ok++;
          end
        endcase
      end
    end
  endtask

  // Monitor: sample both sides at the rising edge; check the output transfer
  // before predicting from the input one.
  always @(posedge clk_i) begin
    src_took  = 1'b0;
    sink_took = 1'b0;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        sink_took = 1'b1;
        results_got++;
        check_beat();
      end
      if (s_axis_tvalid && s_axis_tready) begin
        src_took = 1'b1;
        bytes_sent++;
        frame_decode_step(s_axis_tdata);
      end
      quiet_cycles = (src_took || sink_took) ? 0 : quiet_cycles + 1;
    end
  end

  // --------------------------------------------------------------------------
  // Driver: offer bytes from the queue, with a random gap before each one
  // --------------------------------------------------------------------------
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (src_took) begin
        src_gap = src_burst ? 0 : $urandom_range(0, 7);
        if (bytes_sent % 40 == 0) src_burst = ($urandom_range(0, 3) == 0);
      end
      if (s_axis_tvalid && !src_took) begin
        // hold the current byte until it is taken
      end else if (src_gap > 0) begin
        src_gap--;
        s_axis_tvalid <= 1'b0;
      end else if (rx_stream_q.size() > 0) begin
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= rx_stream_q.pop_front();
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Receiver: random stall after each transfer, one long hold-off on the way
  // --------------------------------------------------------------------------
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (sink_took) begin
        sink_wait = sink_burst ? 0 : $urandom_range(0, 7);
        if (results_got % 32 == 0) sink_burst = ($urandom_range(0, 3) == 0);
        if (!hold_done && results_got >= HOLD_AT) begin
          hold_done = 1'b1;
          hold_left = HOLD_LEN;
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else if (sink_wait > 0) begin
        sink_wait--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------

  // Data frame: header, CRC, then nsend payload bytes (fill < 0 means random).
  task automatic data_frame(input logic [15:0] len, input int nsend, input int fill,
                            input bit bad);
    logic [7:0]  body[$];
    logic [15:0] crc;
    crc = crc16_step(crc16_step(16'h0000, SYNC_BYTE), TYPE_DATA);
    crc = crc16_step(crc16_step(crc, len[7:0]), len[15:8]);
    for (int i = 0; i < nsend; i++) begin
      body.push_back((fill < 0) ? 8'($urandom_range(0, 255)) : 8'(fill));
      crc = crc16_step(crc, body[i]);
    end
    if (bad) crc ^= 16'($urandom_range(1, 16'hFFFF));
    rx_stream_q.push_back(SYNC_BYTE);
    rx_stream_q.push_back(TYPE_DATA);
    rx_stream_q.push_back(len[7:0]);
    rx_stream_q.push_back(len[15:8]);
    rx_stream_q.push_back(crc[7:0]);
    rx_stream_q.push_back(crc[15:8]);
    foreach (body[i]) rx_stream_q.push_back(body[i]);
  endtask

  task automatic ping_frame();
    rx_stream_q.push_back(SYNC_BYTE);
    rx_stream_q.push_back(TYPE_PING);
  endtask

  task automatic reply_frame(input int fill);
    rx_stream_q.push_back(SYNC_BYTE);
    rx_stream_q.push_back(TYPE_REPLY);
    for (int i = 0; i < REPLY_LEN; i++)
      rx_stream_q.push_back((fill < 0) ? 8'($urandom_range(0, 255)) : 8'(fill));
  endtask

  task automatic random_length_frame();
    int          pick;
    logic [15:0] len;
    pick = $urandom_range(0, 99);
    if (pick < 82) len = 16'($urandom_range(0, 12));
    else if (pick < 95) len = 16'($urandom_range(13, 48));
    else len = {8'($urandom_range(1, 255)), 8'($urandom_range(0, 255))};
    // Long frames end in overflow; send no more than the decoder will take
    data_frame(len, (len > MAX_PAY) ? MAX_PAY : int'(len), -1, $urandom_range(0, 7) == 0);
  endtask

  task automatic build_stimulus();
    int         base, pick, n;
    logic [7:0] junk;
    logic [15:0] len;

    // Directed part: boundaries, every frame kind and the odd corners
    ping_frame();
    data_frame(16'd0, 0, -1, 1'b0);          // empty frame, good CRC
    data_frame(16'd0, 0, -1, 1'b1);          // empty frame, bad CRC
    data_frame(16'd1, 1, 8'h00, 1'b0);
    data_frame(16'd3, 3, 8'hFF, 1'b0);
    data_frame(16'd4, 4, -1, 1'b1);          // payload CRC mismatch
    reply_frame(8'h00);
    reply_frame(8'hFF);
    rx_stream_q.push_back(SYNC_BYTE);        // unknown type, then a ping type
    rx_stream_q.push_back(8'h00);
    rx_stream_q.push_back(TYPE_PING);
    rx_stream_q.push_back(SYNC_BYTE);        // repeated sync ahead of a data frame
    data_frame(16'd2, 2, -1, 1'b0);
    rx_stream_q.push_back(8'hFF);            // stray bytes while hunting sync
    rx_stream_q.push_back(TYPE_DATA);
    rx_stream_q.push_back(TYPE_REPLY);
    rx_stream_q.push_back(SYNC_BYTE);        // unknown type, then a reply type
    rx_stream_q.push_back(8'hFF);
    rx_stream_q.push_back(TYPE_REPLY);
    for (int i = 0; i < REPLY_LEN; i++) rx_stream_q.push_back(8'($urandom_range(0, 255)));
    data_frame(16'(MAX_PAY), MAX_PAY, -1, 1'b0);  // ends exactly at overflow
    ping_frame();

    // Random part: mostly well-formed frames, the rest noise and broken frames
    base = rx_stream_q.size();
    while (rx_stream_q.size() - base < RAND_BYTES) begin
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
        random_length_frame();
      end else if (pick < 60) begin
        ping_frame();
      end else if (pick < 70) begin
        reply_frame(-1);
      end else if (pick < 78) begin
        n = $urandom_range(1, 5);
        repeat (n) rx_stream_q.push_back(8'($urandom_range(0, 255)));
      end else if (pick < 86) begin
        // sync followed by a type byte that means nothing
        do junk = 8'($urandom_range(0, 255));
        while (junk == TYPE_DATA || junk == TYPE_PING || junk == TYPE_REPLY);
        rx_stream_q.push_back(SYNC_BYTE);
        rx_stream_q.push_back(junk);
      end else if (pick < 94) begin
        // payload cut short: what follows is taken as payload
        len = 16'($urandom_range(1, 12));
        data_frame(len, $urandom_range(0, int'(len) - 1), -1, 1'b0);
      end else begin
        // header cut short: later bytes become length and CRC
        rx_stream_q.push_back(SYNC_BYTE);
        rx_stream_q.push_back(TYPE_DATA);
        n = $urandom_range(0, 3);
        repeat (n) rx_stream_q.push_back(8'($urandom_range(0, 255)));
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Sequencing and end of run
  // --------------------------------------------------------------------------
  initial begin
    build_stimulus();
    repeat (2) @(posedge clk_i);
    #3 rst_ni = 1'b1;
    // drain: every byte offered and taken, every prediction matched
    while (rx_stream_q.size() != 0 || s_axis_tvalid || decoded_q.size() != 0)
      @(negedge clk_i);
    repeat (TAIL_CYCLES) @(negedge clk_i);
    $display("Run covered %0d received bytes and %0d decoded transfers.", bytes_sent,
             results_got);
    $display("Frames: %0d data ok, %0d CRC errors, %0d overflows, %0d pings, %0d replies.",
             n_data_ok, n_data_crc, n_data_ovf, n_pings, n_replies);
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // Watchdog: too long without any transfer on either side ends the run.
  initial begin
    while (quiet_cycles < IDLE_LIMIT) @(posedge clk_i);
    $display("%0t ns: no transfer for %0d cycles, %0d results still expected", $time,
             IDLE_LIMIT, decoded_q.size());
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
